/* sv/clns_pkg.sv */
`timescale 1ns / 1ps

package clns_pkg;

    // Input beat: one LCD command
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
    } clns_cmd_t;

    // Output beat: one enable strobe
    typedef struct packed {
        logic        reg_select;
        logic [3:0]  data_nibble;
        logic [12:0] wait_us;
        logic        last;
    } clns_strobe_t;

    // Command kinds
    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHAR_LIMIT     = 2'd0;
    localparam logic [1:0] CFG_SPLIT_COLUMN   = 2'd1;
    localparam logic [1:0] CFG_SECOND_ADDRESS = 2'd2;
    localparam logic [1:0] CFG_TWO_LINE_MODE  = 2'd3;

    // Strobe program being played out
    typedef enum logic [1:0] {
        MODE_INIT,
        MODE_CLEAR,
        MODE_WRITE
    } clns_mode_t;

    // LCD command bytes
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0c;
    localparam logic [7:0] CMD_FUNC_2LINE  = 8'h28;
    localparam logic [7:0] CMD_FUNC_1LINE  = 8'h20;
    localparam logic [3:0] NIB_WAKE        = 4'h3;
    localparam logic [3:0] NIB_4BIT        = 4'h2;
    localparam logic       SET_ADDR_BIT    = 1'b1;

    // Waits in microseconds
    localparam logic [12:0] WAIT_STROBE = 13'd1;
    localparam logic [12:0] WAIT_BYTE   = 13'd101;
    localparam logic [12:0] WAIT_CLEAR  = 13'd2101;
    localparam logic [12:0] WAIT_WAKE0  = 13'd5001;
    localparam logic [12:0] WAIT_WAKE1  = 13'd201;

    // Step numbers
    localparam logic [3:0] STEP_FIRST      = 4'd0;
    localparam logic [3:0] STEP_CHAR       = 4'd2;
    localparam logic [3:0] STEP_WAKE_LAST  = 4'd3;
    localparam logic [3:0] STEP_LAST_INIT  = 4'd11;
    localparam logic [3:0] STEP_LAST_CLEAR = 4'd1;
    localparam logic [3:0] STEP_LAST_WRITE = 4'd3;

    // Reset values of the configuration registers
    localparam logic [6:0] RST_CHAR_LIMIT     = 7'd16;
    localparam logic [6:0] RST_SPLIT_COLUMN   = 7'd8;
    localparam logic [6:0] RST_SECOND_ADDRESS = 7'd40;
    localparam logic       RST_TWO_LINE_MODE  = 1'b1;

endpackage

/* sv/char_lcd_nibble_sequencer_core.sv */
`timescale 1ns / 1ps

// Character LCD 4-bit write sequencer.
// The s_ channel takes one command per beat (init, clear, write character);
// the m_ channel gives the enable strobes that command causes, one strobe
// per beat, each with RS, the D7..D4 nibble, the least wait after it and a
// last mark on the final strobe of the run.
// Strobes per command: init 12, clear 2, write 2 (4 at the split column,
// where a set-address byte goes first), dropped write or unused kind 0.
// The first strobe of a command passes through the command stage and then
// the output register onto m_. One strobe leaves per cycle while m_ready
// is high and a command is staged; the next command is taken in the cycle
// its last strobe moves into the output register, so the output does not
// gap between back-to-back commands that have strobes.
// The strobe counter walking one command's program sets the rate.
// Reset (aresetn low, synchronous) empties both stages, clears the column
// and loads the configuration defaults (limit 16, split 8, address 40,
// two-line mode). A stalled receiver holds the output register; the
// counter then holds and s_ready drops once a command is waiting.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
module char_lcd_nibble_sequencer_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  clns_pkg::clns_cmd_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output clns_pkg::clns_strobe_t m_data,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [6:0]            cfg_wdata
);
    import clns_pkg::*;

    // Configuration
    logic [6:0] char_limit_reg;
    logic [6:0] split_column_reg;
    logic [6:0] second_address_reg;
    logic       two_line_mode_reg;

    // Column count and command stage
    logic [6:0]   column_reg, column_next;
    logic         item_valid_reg, item_valid_next;
    clns_mode_t   mode_reg, mode_next;
    logic [3:0]   step_reg, step_next;
    logic [7:0]   code_reg, code_next;

    // Output register
    logic         out_valid_reg, out_valid_next;
    clns_strobe_t out_data_reg, out_data_next;

    // Strobe decode
    logic [7:0]   seq_byte;
    logic         seq_rs;
    logic [3:0]   last_step;
    clns_strobe_t strobe;
    logic         load;
    logic         at_last;
    logic         s_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_limit_reg     <= RST_CHAR_LIMIT;
            split_column_reg   <= RST_SPLIT_COLUMN;
            second_address_reg <= RST_SECOND_ADDRESS;
            two_line_mode_reg  <= RST_TWO_LINE_MODE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHAR_LIMIT:     char_limit_reg     <= cfg_wdata;
                CFG_SPLIT_COLUMN:   split_column_reg   <= cfg_wdata;
                CFG_SECOND_ADDRESS: second_address_reg <= cfg_wdata;
                CFG_TWO_LINE_MODE:  two_line_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Build the byte for the current step, then pick its half
    always_comb begin
        seq_byte  = CMD_CLEAR;
        seq_rs    = 1'b0;
        last_step = STEP_LAST_INIT;
        case (mode_reg)
            MODE_INIT: begin
                last_step = STEP_LAST_INIT;
                case (step_reg[3:1])
                    3'd2:    seq_byte = CMD_ENTRY_MODE;
                    3'd3:    seq_byte = CMD_DISPLAY_ON;
                    3'd4:    seq_byte = two_line_mode_reg ? CMD_FUNC_2LINE : CMD_FUNC_1LINE;
                    default: seq_byte = CMD_CLEAR;
                endcase
            end
            MODE_CLEAR: begin
                last_step = STEP_LAST_CLEAR;
                seq_byte  = CMD_CLEAR;
            end
            MODE_WRITE: begin
                last_step = STEP_LAST_WRITE;
                if (step_reg[1]) begin
                    seq_rs   = 1'b1;
                    seq_byte = code_reg;
                end else begin
                    seq_byte = {SET_ADDR_BIT, second_address_reg};
                end
            end
            default: ;
        endcase

        strobe.reg_select  = seq_rs;
        strobe.data_nibble = step_reg[0] ? seq_byte[3:0] : seq_byte[7:4];
        if (!step_reg[0]) begin
            strobe.wait_us = WAIT_STROBE;
        end else if (!seq_rs && seq_byte == CMD_CLEAR) begin
            strobe.wait_us = WAIT_CLEAR;
        end else begin
            strobe.wait_us = WAIT_BYTE;
        end

        // Wake nibbles lead the init program
        if (mode_reg == MODE_INIT && step_reg <= STEP_WAKE_LAST) begin
            strobe.data_nibble = (step_reg == STEP_WAKE_LAST) ? NIB_4BIT : NIB_WAKE;
            case (step_reg[1:0])
                2'd0:    strobe.wait_us = WAIT_WAKE0;
                2'd1:    strobe.wait_us = WAIT_WAKE1;
                default: strobe.wait_us = WAIT_BYTE;
            endcase
        end

        strobe.last = (step_reg == last_step);
    end

    // Handshake: advance the program whenever the output register frees up
    assign at_last = (step_reg == last_step);
    assign load    = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || (load && at_last);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        column_next     = column_reg;
        item_valid_next = item_valid_reg;
        mode_next       = mode_reg;
        step_next       = step_reg;
        code_next       = code_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (load) begin
            out_valid_next = 1'b1;
            out_data_next  = strobe;
            step_next      = step_reg + 4'd1;
            if (at_last) begin
                item_valid_next = 1'b0;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (s_fire) begin
            code_next = s_data.char_code;
            step_next = STEP_FIRST;
            case (s_data.kind)
                KIND_INIT: begin
                    item_valid_next = 1'b1;
                    mode_next       = MODE_INIT;
                    column_next     = '0;
                end
                KIND_CLEAR: begin
                    item_valid_next = 1'b1;
                    mode_next       = MODE_CLEAR;
                    column_next     = '0;
                end
                KIND_WRITE: begin
                    // Drop characters past the limit
                    if (column_reg < char_limit_reg) begin
                        item_valid_next = 1'b1;
                        mode_next       = MODE_WRITE;
                        column_next     = column_reg + 7'd1;
                        if (column_reg != split_column_reg) begin
                            step_next = STEP_CHAR;
                        end
                    end else begin
                        item_valid_next = 1'b0;
                    end
                end
                default: item_valid_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= '0;
            item_valid_reg <= 1'b0;
            mode_reg       <= MODE_INIT;
            step_reg       <= STEP_FIRST;
            out_valid_reg  <= 1'b0;
        end else begin
            column_reg     <= column_next;
            item_valid_reg <= item_valid_next;
            mode_reg       <= mode_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg     <= code_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
